>>> design/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the heightmap sampler
// Concurrent checks, compiled out when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// property must hold on every rising clock edge outside reset
`define HBS_ASSERT(lbl, c, r, prop) \
    lbl: assert property (@(posedge c) disable iff (!r) prop) \
        else $error("hbs assertion failed");
// expression must never be true outside reset
`define HBS_NEVER(lbl, c, r, expr) \
    lbl: assert property (@(posedge c) disable iff (!r) !(expr)) \
        else $error("hbs forbidden condition seen");
`else
`define HBS_ASSERT(lbl, c, r, prop)
`define HBS_NEVER(lbl, c, r, expr)
`endif
`endif

>>> design/hbs_pkg.sv
// ----------------------------------------------------------------------------
// hbs_pkg
// Shared types and constants of the heightmap bilinear sampler.
// ----------------------------------------------------------------------------
`default_nettype none

package hbs_pkg;

    localparam int GRID_SIZE_DEF  = 33;
    localparam int POST_SHIFT_DEF = 7;
    localparam int FRAC_BITS_DEF  = 8;

    localparam int INDEX_W     = 11;
    localparam int VALUE_W     = 32;
    localparam int IN_DATA_W   = 112;
    localparam int OUT_DATA_W  = 32;
    localparam int CFG_INDEX_W = 2;

    // widest post address (257 x 257 posts) and widest fraction
    localparam int ADDR_MAX_W = 17;
    localparam int FRAC_MAX_W = 16;

    localparam int QUEUE_DEPTH = 4;

    localparam logic [CFG_INDEX_W-1:0] CFG_ORIGIN_X    = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_ORIGIN_Z    = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_CELL_LOADED = 2'd2;

    localparam logic signed [VALUE_W-1:0] ORIGIN_X_RESET = 32'sd0;
    localparam logic signed [VALUE_W-1:0] ORIGIN_Z_RESET = -32'sd1048576;

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    typedef struct packed {
        logic signed [VALUE_W-1:0] origin_x;
        logic signed [VALUE_W-1:0] origin_z;
        logic                      loaded;
    } cfg_t;

    typedef enum logic [1:0] {
        ENT_WRITE,
        ENT_MISS,
        ENT_HIT
    } entry_kind_t;

    typedef struct packed {
        entry_kind_t               kind;
        logic [ADDR_MAX_W-1:0]     addr;
        logic signed [VALUE_W-1:0] height;
        logic [FRAC_MAX_W-1:0]     fx;
        logic [FRAC_MAX_W-1:0]     fz;
        logic                      step_x;
        logic                      step_z;
    } entry_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_TAP,
        BK_WAIT
    } back_state_t;

endpackage

`default_nettype wire

>>> design/hbs_front.sv
// ----------------------------------------------------------------------------
// hbs_front
// Accepts input items, runs the cell test and grid split, emits queue entries.
// ----------------------------------------------------------------------------
`default_nettype none

module hbs_front #(
    parameter int GRID_SIZE  = hbs_pkg::GRID_SIZE_DEF,
    parameter int POST_SHIFT = hbs_pkg::POST_SHIFT_DEF,
    parameter int FRAC_BITS  = hbs_pkg::FRAC_BITS_DEF
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire hbs_pkg::cfg_t                     cfg,
    input  wire logic                              in_valid,
    output logic                                   in_ready,
    input  wire logic                              in_op,
    input  wire logic [hbs_pkg::INDEX_W-1:0]       in_index,
    input  wire logic signed [hbs_pkg::VALUE_W-1:0] in_height,
    input  wire logic signed [hbs_pkg::VALUE_W-1:0] in_qx,
    input  wire logic signed [hbs_pkg::VALUE_W-1:0] in_qz,
    output logic                                   push,
    output hbs_pkg::entry_t                        entry,
    input  wire logic                              full
);

    localparam int POSTS     = GRID_SIZE * GRID_SIZE;
    localparam int POS_SHIFT = POST_SHIFT + FRAC_BITS;
    localparam int COORD_W   = $clog2(GRID_SIZE);
    localparam int ADDR_W    = $clog2(POSTS);
    localparam int FRAC_W    = (FRAC_BITS > 0) ? FRAC_BITS : 1;
    localparam int DIFF_W    = hbs_pkg::VALUE_W + 1;
    localparam longint SPAN  = longint'(GRID_SIZE - 1) << POS_SHIFT;
    localparam logic [FRAC_W-1:0]  FRAC_MASK = (FRAC_BITS > 0) ? '1 : '0;
    localparam logic [COORD_W-1:0] LAST_POST = COORD_W'(GRID_SIZE - 1);
    localparam logic [DIFF_W-1:0]  LAST_WIDE = DIFF_W'(GRID_SIZE - 1);

    // stage 1: item and offsets from the cell corner
    logic                              s1_valid_reg;
    logic                              s1_op_reg;
    logic [hbs_pkg::INDEX_W-1:0]       s1_index_reg;
    logic signed [hbs_pkg::VALUE_W-1:0] s1_height_reg;
    logic signed [DIFF_W-1:0]          s1_dx_reg;
    logic signed [DIFF_W-1:0]          s1_dz_reg;

    // stage 2: classified entry
    logic            s2_valid_reg;
    hbs_pkg::entry_t s2_entry_reg;

    logic s1_ready;
    logic s2_ready;

    logic signed [63:0] dx_wide;
    logic signed [63:0] dz_wide;
    logic               x_in;
    logic               z_in;
    logic               query_hit;
    logic               write_ok;
    logic [DIFF_W-1:0]  ux;
    logic [DIFF_W-1:0]  uz;
    logic [DIFF_W-1:0]  ix;
    logic [DIFF_W-1:0]  iz;
    logic [COORD_W-1:0] x0;
    logic [COORD_W-1:0] z0;
    logic [FRAC_W-1:0]  fx;
    logic [FRAC_W-1:0]  fz;
    logic [ADDR_W-1:0]  base;
    hbs_pkg::entry_t    s2_entry_next;
    logic               s2_valid_next;

    assign s2_ready = !s2_valid_reg || !full;
    assign s1_ready = !s1_valid_reg || s2_ready;
    assign in_ready = s1_ready;
    assign push     = s2_valid_reg && !full;
    assign entry    = s2_entry_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_ready)
            begin
                s1_valid_reg <= in_valid;
            end
            if (s2_ready)
            begin
                s2_valid_reg <= s2_valid_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && s1_ready)
        begin
            s1_op_reg     <= in_op;
            s1_index_reg  <= in_index;
            s1_height_reg <= in_height;
            s1_dx_reg     <= DIFF_W'(in_qx) - DIFF_W'(cfg.origin_x);
            s1_dz_reg     <= DIFF_W'(in_qz) - DIFF_W'(cfg.origin_z);
        end
        if (s2_ready)
        begin
            s2_entry_reg <= s2_entry_next;
        end
    end

    // cell test: X closed at the low end, Z closed at the high end
    always_comb
    begin
        dx_wide   = 64'(s1_dx_reg);
        dz_wide   = 64'(s1_dz_reg);
        x_in      = (dx_wide >= 64'sd0) && (dx_wide < SPAN);
        z_in      = (dz_wide > 64'sd0) && (dz_wide <= SPAN);
        query_hit = cfg.loaded && x_in && z_in;
        write_ok  = int'(s1_index_reg) < POSTS;
    end

    // split offsets into post and fraction, clamp to the last post
    always_comb
    begin
        ux = s1_dx_reg;
        uz = s1_dz_reg;
        ix = ux >> POS_SHIFT;
        iz = uz >> POS_SHIFT;
        if (ix >= LAST_WIDE)
        begin
            x0 = LAST_POST;
            fx = '0;
        end
        else
        begin
            x0 = ix[COORD_W-1:0];
            fx = FRAC_W'(ux >> POST_SHIFT) & FRAC_MASK;
        end
        if (iz >= LAST_WIDE)
        begin
            z0 = LAST_POST;
            fz = '0;
        end
        else
        begin
            z0 = iz[COORD_W-1:0];
            fz = FRAC_W'(uz >> POST_SHIFT) & FRAC_MASK;
        end
        base = ADDR_W'(int'(z0) * GRID_SIZE + int'(x0));
    end

    always_comb
    begin
        s2_entry_next        = '0;
        s2_entry_next.height = s1_height_reg;
        s2_entry_next.fx     = hbs_pkg::FRAC_MAX_W'(fx);
        s2_entry_next.fz     = hbs_pkg::FRAC_MAX_W'(fz);
        s2_entry_next.step_x = (x0 != LAST_POST);
        s2_entry_next.step_z = (z0 != LAST_POST);
        if (s1_op_reg == hbs_pkg::OP_WRITE)
        begin
            s2_entry_next.kind = hbs_pkg::ENT_WRITE;
            s2_entry_next.addr = hbs_pkg::ADDR_MAX_W'(ADDR_W'(s1_index_reg));
            // drop writes beyond the grid
            s2_valid_next      = s1_valid_reg && write_ok;
        end
        else
        begin
            s2_entry_next.kind = query_hit ? hbs_pkg::ENT_HIT : hbs_pkg::ENT_MISS;
            s2_entry_next.addr = hbs_pkg::ADDR_MAX_W'(base);
            s2_valid_next      = s1_valid_reg;
        end
    end

endmodule

`default_nettype wire

>>> design/hbs_queue.sv
// ----------------------------------------------------------------------------
// hbs_queue
// Short FIFO of classified entries between front and back.
// ----------------------------------------------------------------------------
`default_nettype none

module hbs_queue (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            push,
    input  wire hbs_pkg::entry_t push_entry,
    output logic                 full,
    output logic                 valid,
    output hbs_pkg::entry_t      head,
    input  wire logic            pop
);

    localparam int PTR_W = $clog2(hbs_pkg::QUEUE_DEPTH);
    localparam logic [PTR_W:0] DEPTH_CNT = (PTR_W + 1)'(hbs_pkg::QUEUE_DEPTH);

    hbs_pkg::entry_t  entries_reg [hbs_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W:0]   count_reg;
    logic [PTR_W:0]   count_next;

    assign full  = (count_reg == DEPTH_CNT);
    assign valid = (count_reg != '0);
    assign head  = entries_reg[rd_ptr_reg];

    always_comb
    begin
        case ({push, pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entries_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

`default_nettype wire

>>> design/hbs_back.sv
// ----------------------------------------------------------------------------
// hbs_back
// Post memory, four-tap bilinear blend and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module hbs_back #(
    parameter int GRID_SIZE = hbs_pkg::GRID_SIZE_DEF,
    parameter int FRAC_BITS = hbs_pkg::FRAC_BITS_DEF
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              q_valid,
    input  wire hbs_pkg::entry_t                   q_entry,
    output logic                                   q_pop,
    output logic                                   out_valid,
    input  wire logic                              out_ready,
    output logic                                   out_hit,
    output logic signed [hbs_pkg::VALUE_W-1:0]     out_height
);

    localparam int POSTS  = GRID_SIZE * GRID_SIZE;
    localparam int ADDR_W = $clog2(POSTS);
    localparam int FRAC_W = (FRAC_BITS > 0) ? FRAC_BITS : 1;
    localparam int WGT_W  = FRAC_BITS + 1;
    localparam int PROD_W = hbs_pkg::VALUE_W + 2 * WGT_W + 1;
    localparam int ACC_W  = PROD_W + 2;
    localparam int SHIFT  = 2 * FRAC_BITS;
    localparam logic [WGT_W-1:0]        ONE  = WGT_W'(1) << FRAC_BITS;
    localparam logic signed [ACC_W-1:0] HALF = (ACC_W'(1) << SHIFT) >> 1;
    localparam logic [ADDR_W-1:0]       ROW  = ADDR_W'(GRID_SIZE);

    logic signed [hbs_pkg::VALUE_W-1:0] mem [POSTS];

    hbs_pkg::back_state_t state_reg;
    hbs_pkg::back_state_t state_next;

    logic [1:0]        tap_reg;
    logic [ADDR_W-1:0] base_reg;
    logic              step_x_reg;
    logic              step_z_reg;
    logic [FRAC_W-1:0] fx_reg;
    logic [FRAC_W-1:0] fz_reg;

    logic signed [hbs_pkg::VALUE_W-1:0] rdata_reg;
    logic [2*WGT_W-1:0]                 w_reg;
    logic                               p1_valid_reg;
    logic                               p1_first_reg;
    logic                               p1_last_reg;
    logic signed [PROD_W-1:0]           prod_reg;
    logic                               p2_valid_reg;
    logic                               p2_first_reg;
    logic                               p2_last_reg;
    logic signed [ACC_W-1:0]            acc_reg;
    logic                               acc_done_reg;

    logic                               out_valid_reg;
    logic                               out_hit_reg;
    logic signed [hbs_pkg::VALUE_W-1:0] out_height_reg;

    logic               out_free;
    logic               mem_we;
    logic               tap_issue;
    logic               load_work;
    logic               load_miss;
    logic               load_hit;
    logic [ADDR_W-1:0]  rd_addr;
    logic [WGT_W-1:0]   wx;
    logic [WGT_W-1:0]   wz;
    logic signed [2*WGT_W:0]  wgt_s;
    logic signed [PROD_W-1:0] prod_next;
    logic signed [ACC_W-1:0]  rnd;

    assign out_free   = !out_valid_reg || out_ready;
    assign out_valid  = out_valid_reg;
    assign out_hit    = out_hit_reg;
    assign out_height = out_height_reg;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            hbs_pkg::BK_IDLE:
            begin
                if (q_valid && (q_entry.kind == hbs_pkg::ENT_HIT))
                begin
                    state_next = hbs_pkg::BK_TAP;
                end
            end
            hbs_pkg::BK_TAP:
            begin
                if (tap_reg == 2'd3)
                begin
                    state_next = hbs_pkg::BK_WAIT;
                end
            end
            hbs_pkg::BK_WAIT:
            begin
                if (acc_done_reg && out_free)
                begin
                    state_next = hbs_pkg::BK_IDLE;
                end
            end
            default: state_next = hbs_pkg::BK_IDLE;
        endcase
    end

    // state outputs
    always_comb
    begin
        q_pop     = 1'b0;
        mem_we    = 1'b0;
        tap_issue = 1'b0;
        load_work = 1'b0;
        load_miss = 1'b0;
        load_hit  = 1'b0;
        unique case (state_reg)
            hbs_pkg::BK_IDLE:
            begin
                if (q_valid)
                begin
                    unique case (q_entry.kind)
                        hbs_pkg::ENT_WRITE:
                        begin
                            q_pop  = 1'b1;
                            mem_we = 1'b1;
                        end
                        hbs_pkg::ENT_MISS:
                        begin
                            q_pop     = out_free;
                            load_miss = out_free;
                        end
                        hbs_pkg::ENT_HIT:
                        begin
                            q_pop     = 1'b1;
                            load_work = 1'b1;
                        end
                        default: q_pop = 1'b1;
                    endcase
                end
            end
            hbs_pkg::BK_TAP:  tap_issue = 1'b1;
            hbs_pkg::BK_WAIT: load_hit  = acc_done_reg && out_free;
            default: ;
        endcase
    end

    // tap 0..3 walks (x0,z0) (x1,z0) (x0,z1) (x1,z1)
    always_comb
    begin
        rd_addr = base_reg + ADDR_W'(tap_reg[0] & step_x_reg)
                + ((tap_reg[1] && step_z_reg) ? ROW : '0);
        wx      = tap_reg[0] ? WGT_W'(fx_reg) : ONE - WGT_W'(fx_reg);
        wz      = tap_reg[1] ? WGT_W'(fz_reg) : ONE - WGT_W'(fz_reg);
        wgt_s     = $signed({1'b0, w_reg});
        prod_next = PROD_W'(rdata_reg) * PROD_W'(wgt_s);
        rnd       = acc_reg + HALF;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= hbs_pkg::BK_IDLE;
            tap_reg       <= '0;
            p1_valid_reg  <= 1'b0;
            p1_first_reg  <= 1'b0;
            p1_last_reg   <= 1'b0;
            p2_valid_reg  <= 1'b0;
            p2_first_reg  <= 1'b0;
            p2_last_reg   <= 1'b0;
            acc_done_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (load_work)
            begin
                tap_reg <= '0;
            end
            else if (tap_issue)
            begin
                tap_reg <= tap_reg + 1'b1;
            end
            p1_valid_reg <= tap_issue;
            p1_first_reg <= (tap_reg == 2'd0);
            p1_last_reg  <= (tap_reg == 2'd3);
            p2_valid_reg <= p1_valid_reg;
            p2_first_reg <= p1_first_reg;
            p2_last_reg  <= p1_last_reg;
            if (load_hit)
            begin
                acc_done_reg <= 1'b0;
            end
            else if (p2_valid_reg && p2_last_reg)
            begin
                acc_done_reg <= 1'b1;
            end
            if (load_miss || load_hit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // single-port post memory: one write or one read per cycle
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[ADDR_W'(q_entry.addr)] <= q_entry.height;
        end
        if (tap_issue)
        begin
            rdata_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_work)
        begin
            base_reg   <= ADDR_W'(q_entry.addr);
            step_x_reg <= q_entry.step_x;
            step_z_reg <= q_entry.step_z;
            fx_reg     <= FRAC_W'(q_entry.fx);
            fz_reg     <= FRAC_W'(q_entry.fz);
        end
        if (tap_issue)
        begin
            w_reg <= (2 * WGT_W)'(wx) * (2 * WGT_W)'(wz);
        end
        prod_reg <= prod_next;
        if (p2_valid_reg)
        begin
            acc_reg <= p2_first_reg ? ACC_W'(prod_reg) : acc_reg + ACC_W'(prod_reg);
        end
        if (load_miss)
        begin
            out_hit_reg    <= 1'b0;
            out_height_reg <= '0;
        end
        else if (load_hit)
        begin
            out_hit_reg    <= 1'b1;
            out_height_reg <= hbs_pkg::VALUE_W'(rnd >>> SHIFT);
        end
    end

endmodule

`default_nettype wire

>>> design/heightmap_bilinear_sampler.sv
// ----------------------------------------------------------------------------
// heightmap_bilinear_sampler - bilinear height lookup in one terrain cell
// A hit query holds the back end for four reads of the single-port post memory
// plus the multiply/accumulate drain, and the back end takes no new entry meanwhile.
// Reset: asynchronous; clears config to its defaults, empties queue and output.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module heightmap_bilinear_sampler #(
    parameter int GRID_SIZE  = hbs_pkg::GRID_SIZE_DEF,
    parameter int POST_SHIFT = hbs_pkg::POST_SHIFT_DEF,
    parameter int FRAC_BITS  = hbs_pkg::FRAC_BITS_DEF
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    // input stream
    input  wire logic                               s_tvalid,
    output logic                                    s_tready,
    // post_index[10:0], post_height[42:11], query_x[74:43], query_z[106:75], zero pad
    input  wire logic [hbs_pkg::IN_DATA_W-1:0]      s_tdata,
    // operation: 0 post write, 1 height query
    input  wire logic                               s_tuser,
    // result stream
    output logic                                    m_tvalid,
    input  wire logic                               m_tready,
    // height[31:0]
    output logic [hbs_pkg::OUT_DATA_W-1:0]          m_tdata,
    // hit
    output logic                                    m_tuser,
    // configuration write channel
    input  wire logic                               cfg_valid,
    output logic                                    cfg_ready,
    input  wire logic [hbs_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  wire logic [hbs_pkg::VALUE_W-1:0]        cfg_data
);

    // Item fields inside s_tdata, lowest bit first.
    localparam int IDX_LSB = 0;
    localparam int PH_LSB  = IDX_LSB + hbs_pkg::INDEX_W;
    localparam int QX_LSB  = PH_LSB + hbs_pkg::VALUE_W;
    localparam int QZ_LSB  = QX_LSB + hbs_pkg::VALUE_W;

    hbs_pkg::cfg_t cfg_reg;

    logic            q_push;
    logic            q_full;
    logic            q_valid;
    logic            q_pop;
    hbs_pkg::entry_t front_entry;
    hbs_pkg::entry_t q_head;

    logic                               out_hit;
    logic signed [hbs_pkg::VALUE_W-1:0] out_height;

    // Configuration is always taken; unknown indexes drop the transfer.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.origin_x <= hbs_pkg::ORIGIN_X_RESET;
            cfg_reg.origin_z <= hbs_pkg::ORIGIN_Z_RESET;
            cfg_reg.loaded   <= 1'b0;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                hbs_pkg::CFG_ORIGIN_X:    cfg_reg.origin_x <= cfg_data;
                hbs_pkg::CFG_ORIGIN_Z:    cfg_reg.origin_z <= cfg_data;
                hbs_pkg::CFG_CELL_LOADED: cfg_reg.loaded   <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // Front end: subtract the cell corner, test the cell bounds, split into
    // post and fraction, and hand one entry per item to the queue. Writes
    // beyond the grid are dropped here.
    hbs_front #(
        .GRID_SIZE  (GRID_SIZE),
        .POST_SHIFT (POST_SHIFT),
        .FRAC_BITS  (FRAC_BITS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_op     (s_tuser),
        .in_index  (s_tdata[IDX_LSB +: hbs_pkg::INDEX_W]),
        .in_height (s_tdata[PH_LSB +: hbs_pkg::VALUE_W]),
        .in_qx     (s_tdata[QX_LSB +: hbs_pkg::VALUE_W]),
        .in_qz     (s_tdata[QZ_LSB +: hbs_pkg::VALUE_W]),
        .push      (q_push),
        .entry     (front_entry),
        .full      (q_full)
    );

    // Queue: lets the front keep taking items while the back end works on a query.
    hbs_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_entry (front_entry),
        .full       (q_full),
        .valid      (q_valid),
        .head       (q_head),
        .pop        (q_pop)
    );

    // Back end: stores posts, and for a hit walks the four neighbor posts
    // through one multiplier into an exact accumulator, then rounds.
    hbs_back #(
        .GRID_SIZE (GRID_SIZE),
        .FRAC_BITS (FRAC_BITS)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_valid    (q_valid),
        .q_entry    (q_head),
        .q_pop      (q_pop),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_hit    (out_hit),
        .out_height (out_height)
    );

    assign m_tdata = out_height;
    assign m_tuser = out_hit;

    // The front never pushes into a full queue, the back never pops an empty one.
    `HBS_NEVER(a_queue_overflow, clk, rst_n, q_push && q_full)
    `HBS_NEVER(a_queue_underflow, clk, rst_n, q_pop && !q_valid)

endmodule

`default_nettype wire
